/* sv/apio_pkg.sv */
// shared types, constants and fixed-point helpers for the axis projection interval unit
// no dependencies; used by every module of the block by scoped names
`default_nettype none

package apio_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int Q_W             = 32;
  localparam int CFG_COUNT       = 8;
  localparam int CFG_INDEX_W     = 3;
  localparam int PROD_W          = 2 * Q_W;
  localparam int RND_W           = PROD_W - 16;
  localparam int SUM_W           = RND_W + 3;

  localparam logic signed [Q_W-1:0] Q_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [Q_W-1:0] Q_MIN   = 32'sh8000_0000;
  localparam logic signed [Q_W-1:0] Q_ONE   = 32'sh0001_0000;
  localparam logic signed [Q_W-1:0] Q_ZERO  = 32'sh0000_0000;
  localparam logic signed [PROD_W-1:0] RND_HALF = 64'sh0000_0000_0000_8000;

  localparam logic [CFG_INDEX_W-1:0] CFG_ROW0_X_GAIN = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW0_Y_GAIN = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW0_Z_GAIN = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW0_OFFSET = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW1_X_GAIN = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW1_Y_GAIN = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW1_Z_GAIN = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW1_OFFSET = 3'd7;

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_VERTEX = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_t;

  // start: a/b = axis; vertex: a/b/c = x/y/z; query: a/b = other min/max
  typedef struct packed {
    kind_t                  kind;
    logic signed [Q_W-1:0]  a;
    logic signed [Q_W-1:0]  b;
    logic signed [Q_W-1:0]  c;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic deq;
    logic res_load;
  } back_ctrl_t;

  // round half up to q16.16: floor((p + 2^15) / 2^16)
  function automatic logic signed [RND_W-1:0] round_q(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + RND_HALF;
    return $signed(t[PROD_W-1:16]);
  endfunction

  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-Q_W:0] top;
    top = v[SUM_W-1:Q_W-1];
    if (top == '0 || top == '1) begin
      return $signed(v[Q_W-1:0]);
    end else if (v[SUM_W-1]) begin
      return Q_MIN;
    end else begin
      return Q_MAX;
    end
  endfunction

endpackage

`default_nettype wire

/* sv/apio_front.sv */
// front end: accepts requests and classifies them into queue entries
// depends on apio_pkg
`default_nettype none

module apio_front (
  input  wire logic                          push,
  input  wire logic                          full,
  input  wire logic [1:0]                    action,
  input  wire logic signed [apio_pkg::Q_W-1:0] vert_x,
  input  wire logic signed [apio_pkg::Q_W-1:0] vert_y,
  input  wire logic signed [apio_pkg::Q_W-1:0] vert_z,
  input  wire logic signed [apio_pkg::Q_W-1:0] axis_x,
  input  wire logic signed [apio_pkg::Q_W-1:0] axis_y,
  input  wire logic signed [apio_pkg::Q_W-1:0] other_min,
  input  wire logic signed [apio_pkg::Q_W-1:0] other_max,
  output logic                               enq,
  output apio_pkg::entry_t                   entry
);

  logic known;

  always_comb begin
    known      = 1'b1;
    entry.kind = apio_pkg::KIND_START;
    entry.a    = axis_x;
    entry.b    = axis_y;
    entry.c    = apio_pkg::Q_ZERO;
    case (action)
      apio_pkg::KIND_START: begin
        entry.kind = apio_pkg::KIND_START;
      end
      apio_pkg::KIND_VERTEX: begin
        entry.kind = apio_pkg::KIND_VERTEX;
        entry.a    = vert_x;
        entry.b    = vert_y;
        entry.c    = vert_z;
      end
      apio_pkg::KIND_QUERY: begin
        entry.kind = apio_pkg::KIND_QUERY;
        entry.a    = other_min;
        entry.b    = other_max;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // unused action code is taken and dropped
  assign enq = push && !full && known;

endmodule

`default_nettype wire

/* sv/apio_queue.sv */
// short queue of classified requests between front and back end
// depends on apio_pkg
`default_nettype none

module apio_queue #(
  parameter int DEPTH = apio_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              enq,
  input  wire apio_pkg::entry_t  enq_data,
  input  wire logic              deq,
  output apio_pkg::entry_t       head,
  output apio_pkg::q_status_t    status
);

  localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  apio_pkg::entry_t store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (enq) begin
      store[wr_ptr] <= enq_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({enq, deq})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head         = store[rd_ptr];
  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);

endmodule

`default_nettype wire

/* sv/apio_back.sv */
// back end: configuration registers, vertex transform and projection sequencer,
// running interval and result register; depends on apio_pkg
`default_nettype none

module apio_back (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [apio_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic signed [apio_pkg::Q_W-1:0]   cfg_data,
  input  wire apio_pkg::entry_t                  head,
  input  wire apio_pkg::q_status_t               qs,
  output apio_pkg::back_ctrl_t                   ctrl,
  input  wire logic                              res_pop,
  output logic                                   res_valid,
  output logic                                   colliding,
  output logic signed [apio_pkg::Q_W-1:0]        penetration,
  output logic signed [apio_pkg::Q_W-1:0]        interval_min,
  output logic signed [apio_pkg::Q_W-1:0]        interval_max
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SUM0 = 4'b0010,
    ST_MUL1 = 4'b0100,
    ST_SUM1 = 4'b1000
  } back_state_t;

  back_state_t state;
  back_state_t state_next;

  logic signed [apio_pkg::Q_W-1:0]    cfg_regs [apio_pkg::CFG_COUNT];
  logic signed [apio_pkg::Q_W-1:0]    axis_x_held;
  logic signed [apio_pkg::Q_W-1:0]    axis_y_held;
  logic signed [apio_pkg::Q_W-1:0]    run_min;
  logic signed [apio_pkg::Q_W-1:0]    run_max;
  logic signed [apio_pkg::PROD_W-1:0] prod [6];
  logic signed [apio_pkg::PROD_W-1:0] axis_prod0;
  logic signed [apio_pkg::PROD_W-1:0] axis_prod1;
  logic signed [apio_pkg::Q_W-1:0]    tx;
  logic signed [apio_pkg::Q_W-1:0]    ty;

  logic                               res_free;
  logic                               take;
  logic                               deq;
  logic                               res_load;
  logic signed [apio_pkg::SUM_W-1:0]  sum_x;
  logic signed [apio_pkg::SUM_W-1:0]  sum_y;
  logic signed [apio_pkg::SUM_W-1:0]  sum_proj;
  logic signed [apio_pkg::SUM_W-1:0]  sum_pen;
  logic signed [apio_pkg::Q_W-1:0]    proj;
  logic                               apart;

  assign cfg_ready = 1'b1;

  assign res_free = !res_valid || res_pop;
  assign take     = !qs.empty && ((head.kind != apio_pkg::KIND_QUERY) || res_free);
  assign deq      = (state == ST_IDLE) && take;
  assign res_load = deq && (head.kind == apio_pkg::KIND_QUERY);

  assign ctrl.deq      = deq;
  assign ctrl.res_load = res_load;

  always_comb begin
    sum_x = apio_pkg::SUM_W'(apio_pkg::round_q(prod[0]))
          + apio_pkg::SUM_W'(apio_pkg::round_q(prod[1]))
          + apio_pkg::SUM_W'(apio_pkg::round_q(prod[2]))
          + apio_pkg::SUM_W'(cfg_regs[apio_pkg::CFG_ROW0_OFFSET]);
    sum_y = apio_pkg::SUM_W'(apio_pkg::round_q(prod[3]))
          + apio_pkg::SUM_W'(apio_pkg::round_q(prod[4]))
          + apio_pkg::SUM_W'(apio_pkg::round_q(prod[5]))
          + apio_pkg::SUM_W'(cfg_regs[apio_pkg::CFG_ROW1_OFFSET]);
    sum_proj = apio_pkg::SUM_W'(apio_pkg::round_q(axis_prod0))
             + apio_pkg::SUM_W'(apio_pkg::round_q(axis_prod1));
    proj     = apio_pkg::sat_q(sum_proj);
    sum_pen  = apio_pkg::SUM_W'(run_max) - apio_pkg::SUM_W'(head.a);
    apart    = (run_max < head.a) || (run_min > head.b);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (deq && head.kind == apio_pkg::KIND_VERTEX) begin
          state_next = ST_SUM0;
        end
      end
      ST_SUM0: state_next = ST_MUL1;
      ST_MUL1: state_next = ST_SUM1;
      ST_SUM1: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < apio_pkg::CFG_COUNT; i++) begin
        cfg_regs[i] <= apio_pkg::Q_ZERO;
      end
      cfg_regs[apio_pkg::CFG_ROW0_X_GAIN] <= apio_pkg::Q_ONE;
      cfg_regs[apio_pkg::CFG_ROW1_Y_GAIN] <= apio_pkg::Q_ONE;
    end else if (cfg_valid && cfg_ready) begin
      cfg_regs[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_x_held <= apio_pkg::Q_ZERO;
      axis_y_held <= apio_pkg::Q_ZERO;
      run_min     <= apio_pkg::Q_MAX;
      run_max     <= apio_pkg::Q_MIN;
      res_valid   <= 1'b0;
    end else begin
      if (deq && head.kind == apio_pkg::KIND_START) begin
        axis_x_held <= head.a;
        axis_y_held <= head.b;
        run_min     <= apio_pkg::Q_MAX;
        run_max     <= apio_pkg::Q_MIN;
      end else if (state == ST_SUM1) begin
        if (proj < run_min) begin
          run_min <= proj;
        end
        if (proj >= run_max) begin
          run_max <= proj;
        end
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (deq && head.kind == apio_pkg::KIND_VERTEX) begin
      prod[0] <= cfg_regs[apio_pkg::CFG_ROW0_X_GAIN] * head.a;
      prod[1] <= cfg_regs[apio_pkg::CFG_ROW0_Y_GAIN] * head.b;
      prod[2] <= cfg_regs[apio_pkg::CFG_ROW0_Z_GAIN] * head.c;
      prod[3] <= cfg_regs[apio_pkg::CFG_ROW1_X_GAIN] * head.a;
      prod[4] <= cfg_regs[apio_pkg::CFG_ROW1_Y_GAIN] * head.b;
      prod[5] <= cfg_regs[apio_pkg::CFG_ROW1_Z_GAIN] * head.c;
    end
    if (state == ST_SUM0) begin
      tx <= apio_pkg::sat_q(sum_x);
      ty <= apio_pkg::sat_q(sum_y);
    end
    if (state == ST_MUL1) begin
      axis_prod0 <= tx * axis_x_held;
      axis_prod1 <= ty * axis_y_held;
    end
    if (res_load) begin
      colliding    <= !apart;
      penetration  <= apio_pkg::sat_q(sum_pen);
      interval_min <= run_min;
      interval_max <= run_max;
    end
  end

endmodule

`default_nettype wire

/* sv/axis_projection_interval_overlap.sv */
// Separating-axis projection interval unit. Requests enter through a queue-style push port and
// are classified into a short request queue (QUEUE_DEPTH entries); the front end takes one request
// per cycle while the queue has room. The back end pops one request at a time and takes no new one
// while a vertex is in progress: matrix products, row sums, axis products, projection sum and
// interval update, in order, set by the back-end sequencer that shares one datapath per vertex.
// A query result waits in an output register, so the queue keeps filling while it is not popped.
// Configuration writes are always ready. Depends on apio_pkg, apio_front, apio_queue, apio_back.
`default_nettype none

module axis_projection_interval_overlap #(
  parameter int QUEUE_DEPTH = apio_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [1:0]                        action,
  input  wire logic signed [apio_pkg::Q_W-1:0]   vert_x,
  input  wire logic signed [apio_pkg::Q_W-1:0]   vert_y,
  input  wire logic signed [apio_pkg::Q_W-1:0]   vert_z,
  input  wire logic signed [apio_pkg::Q_W-1:0]   axis_x,
  input  wire logic signed [apio_pkg::Q_W-1:0]   axis_y,
  input  wire logic signed [apio_pkg::Q_W-1:0]   other_min,
  input  wire logic signed [apio_pkg::Q_W-1:0]   other_max,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic                                   colliding,
  output logic signed [apio_pkg::Q_W-1:0]        penetration,
  output logic signed [apio_pkg::Q_W-1:0]        interval_min,
  output logic signed [apio_pkg::Q_W-1:0]        interval_max,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [apio_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic signed [apio_pkg::Q_W-1:0]   cfg_data
);

  logic                 enq;
  apio_pkg::entry_t     entry;
  apio_pkg::entry_t     head;
  apio_pkg::q_status_t  qs;
  apio_pkg::back_ctrl_t ctrl;
  logic                 res_valid;
  logic                 res_pop;

  assign full    = qs.full;
  assign empty   = !res_valid;
  assign res_pop = pop && res_valid;

  apio_front u_front (
    .push      (push),
    .full      (qs.full),
    .action    (action),
    .vert_x    (vert_x),
    .vert_y    (vert_y),
    .vert_z    (vert_z),
    .axis_x    (axis_x),
    .axis_y    (axis_y),
    .other_min (other_min),
    .other_max (other_max),
    .enq       (enq),
    .entry     (entry)
  );

  apio_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .enq      (enq),
    .enq_data (entry),
    .deq      (ctrl.deq),
    .head     (head),
    .status   (qs)
  );

  apio_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .head         (head),
    .qs           (qs),
    .ctrl         (ctrl),
    .res_pop      (res_pop),
    .res_valid    (res_valid),
    .colliding    (colliding),
    .penetration  (penetration),
    .interval_min (interval_min),
    .interval_max (interval_max)
  );

  a_enq_only_on_request: assert property (@(posedge clk) disable iff (rst)
    enq |-> (push && !full))
    else $error("queue written without an accepted request");

  a_deq_not_empty: assert property (@(posedge clk) disable iff (rst)
    ctrl.deq |-> !qs.empty)
    else $error("back end popped an empty queue");

  a_result_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !ctrl.res_load) |=> empty)
    else $error("result still shown after being taken");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.res_load |-> (empty || pop))
    else $error("result register overwritten while still waiting");

endmodule

`default_nettype wire
